// ----- design/sto_pkg.sv -----
// Shared types and codes of the sorted timeout queue.
// Depends on nothing; every other design file imports it.
`default_nettype none

package sto_pkg;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_FIRE   = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   // Response status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_NONE      = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DROP,
      OP_COMPACT,
      OP_POP
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SUM,
      ST_INS_PLACE,
      ST_CANCEL,
      ST_COMPACT,
      ST_FIRE,
      ST_QUERY
   } state_type;

   localparam int TIME_BITS   = 64;
   localparam int TAG_W       = 16;
   localparam int HANDLE_BITS = 4;

   typedef struct packed {
      cell_op_type          op;
      logic [TIME_BITS-1:0] when;
      logic [TIME_BITS-1:0] now;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- design/sto_req_if.sv -----
// Request channel of the sorted timeout queue: valid/ready plus one request beat.
// Depends on sto_pkg.
`default_nettype none

interface sto_req_if import sto_pkg::*; ();
   logic                       valid;
   logic                       ready;
   action_type                 action;
   logic [TIME_BITS-1:0]       now;
   logic [TIME_BITS-1:0]       delay_cycles;
   logic [TAG_W-1:0]           callback_tag;
   logic [HANDLE_BITS-1:0]     cancel_handle;

   modport source (output valid, action, now, delay_cycles, callback_tag, cancel_handle,
                   input ready);
   modport sink   (input valid, action, now, delay_cycles, callback_tag, cancel_handle,
                   output ready);
endinterface

`default_nettype wire

// ----- design/sto_rsp_if.sv -----
// Response channel of the sorted timeout queue: valid/ready plus one response beat.
// Depends on sto_pkg.
`default_nettype none

interface sto_rsp_if import sto_pkg::*; ();
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [HANDLE_BITS-1:0] new_handle;
   logic [TAG_W-1:0]       fired_tag;
   logic [TIME_BITS-1:0]   sleep_cycles;
   logic                   last;

   modport source (output valid, status, new_handle, fired_tag, sleep_cycles, last,
                   input ready);
   modport sink   (input valid, status, new_handle, fired_tag, sleep_cycles, last,
                   output ready);
endinterface

`default_nettype wire

// ----- design/sorted_timeout_queue.sv -----
// Top level of the sorted timeout queue: sequencer, free-handle map, response register.
// Depends on sto_pkg, sto_req_if, sto_rsp_if and sto_cell.
//
// Usage:
//   Requests arrive on req_bus (valid/ready), one beat per operation: insert,
//   cancel, fire or sleep query. Responses leave on rsp_bus (valid/ready); every
//   request gives one beat, except fire, which gives one beat per expired entry
//   (last marks the final one) or a single nothing-due beat.
//   Pending timeouts sit in a chain of DEPTH cells sorted by deadline, head at
//   cell 0. Every cell compares its own deadline, so insert and fire need no
//   search; a cancel leaves a hole that moves one cell per cycle to the tail.
//   Work per request: insert adds the deadline, then takes one chain step; query
//     reads the head; cancel on a miss only answers, else it drops the entry and
//     closes the hole past each live entry behind it (up to DEPTH-1); fire pops
//     one due entry per beat. The chain takes one request at a time.
//   A single output register holds the response; the block accepts the next
//   request while it waits. When the receiver stalls, work that must emit a
//   beat holds until the register frees.
//   Reset empties the chain and marks every handle free; no clearing pass.
`default_nettype none

module sorted_timeout_queue import sto_pkg::*; #(
   parameter int DEPTH    = 16,
   parameter int TAG_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sto_req_if.sink   req_bus,
   sto_rsp_if.source rsp_bus
);

   localparam int SLOT_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // FSM and request registers
   state_type            state_ff, state_in;
   action_type           act_ff;
   logic [TIME_BITS-1:0] now_ff, delay_ff, when_ff, when_in;
   logic [TAG_BITS-1:0]  tag_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   // Free-handle map
   logic [DEPTH-1:0]     free_ff, free_in;
   logic [SLOT_BITS-1:0] low_free;
   logic                 any_free;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic [TIME_BITS-1:0]   rsp_sleep_ff, rsp_sleep_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_free;

   // Chain
   cell_ctrl_type        ctrl;
   cell_op_type          op;
   logic [DEPTH-1:0]     valid_vec, stay_vec, due_vec;
   logic [TIME_BITS-1:0] dl_arr   [DEPTH];
   logic [TAG_BITS-1:0]  tag_arr  [DEPTH];
   logic [SLOT_BITS-1:0] slot_arr [DEPTH];
   logic                 hole;

   logic [SLOT_BITS-1:0] hslot;
   logic                 found;
   logic                 req_fire;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign when_in  = now_ff + delay_ff;

   assign ctrl.op   = op;
   assign ctrl.when = when_ff;
   assign ctrl.now  = now_ff;

   // a cancel handle names a live entry only if it is in range and not free
   assign hslot = SLOT_BITS'(handle_ff);
   assign found = (32'(handle_ff) < DEPTH) && !free_ff[hslot];

   // lowest free handle
   always_comb begin
      low_free = '0;
      any_free = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            low_free = SLOT_BITS'(i);
            any_free = 1'b1;
         end
      end
   end

   // an empty cell followed by a full one is a hole still to be closed
   always_comb begin
      hole = 1'b0;
      for (int i = 0; i < DEPTH - 1; i++) begin
         if (!valid_vec[i] && valid_vec[i+1]) begin
            hole = 1'b1;
         end
      end
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic                 lv, ls, rv;
         logic [TIME_BITS-1:0] ld, rd;
         logic [TAG_BITS-1:0]  lt, rt;
         logic [SLOT_BITS-1:0] lsl, rsl;

         if (i == 0) begin : g_head
            // the head sees an always-valid, always-earlier neighbor
            assign lv  = 1'b1;
            assign ls  = 1'b1;
            assign ld  = '0;
            assign lt  = '0;
            assign lsl = '0;
         end else begin : g_body
            assign lv  = valid_vec[i-1];
            assign ls  = stay_vec[i-1];
            assign ld  = dl_arr[i-1];
            assign lt  = tag_arr[i-1];
            assign lsl = slot_arr[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign rv  = 1'b0;
            assign rd  = '0;
            assign rt  = '0;
            assign rsl = '0;
         end else begin : g_next
            assign rv  = valid_vec[i+1];
            assign rd  = dl_arr[i+1];
            assign rt  = tag_arr[i+1];
            assign rsl = slot_arr[i+1];
         end

         sto_cell #(
            .TAG_BITS  (TAG_BITS),
            .SLOT_BITS (SLOT_BITS)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (ctrl),
            .new_tag        (tag_ff),
            .new_slot       (low_free),
            .drop_slot      (hslot),
            .left_valid     (lv),
            .left_stay      (ls),
            .left_deadline  (ld),
            .left_tag       (lt),
            .left_slot      (lsl),
            .right_valid    (rv),
            .right_deadline (rd),
            .right_tag      (rt),
            .right_slot     (rsl),
            .valid          (valid_vec[i]),
            .stay           (stay_vec[i]),
            .due            (due_vec[i]),
            .deadline       (dl_arr[i]),
            .tag            (tag_arr[i]),
            .slot           (slot_arr[i])
         );
      end
   endgenerate

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op            = OP_HOLD;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_sleep_in  = rsp_sleep_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.action)
                  ACT_INSERT: state_in = ST_INS_SUM;
                  ACT_CANCEL: state_in = ST_CANCEL;
                  ACT_FIRE:   state_in = ST_FIRE;
                  ACT_QUERY:  state_in = ST_QUERY;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_SUM: begin
            // deadline sum lands in when_ff this cycle
            state_in = ST_INS_PLACE;
         end
         ST_INS_PLACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = '0;
               rsp_sleep_in = '0;
               rsp_last_in  = 1'b1;
               if (any_free) begin
                  op                = OP_INSERT;
                  free_in[low_free] = 1'b0;
                  rsp_status_in     = STAT_OK;
                  rsp_handle_in     = HANDLE_BITS'(low_free);
               end else begin
                  rsp_status_in = STAT_FULL;
                  rsp_handle_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_CANCEL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_tag_in    = '0;
               rsp_sleep_in  = '0;
               rsp_last_in   = 1'b1;
               if (found) begin
                  op             = OP_DROP;
                  free_in[hslot] = 1'b1;
                  rsp_status_in  = STAT_OK;
                  state_in       = ST_COMPACT;
               end else begin
                  rsp_status_in = STAT_NOT_FOUND;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_COMPACT: begin
            // advance the hole toward the tail until the chain is dense again
            if (hole) begin
               op = OP_COMPACT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIRE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_sleep_in  = '0;
               if (due_vec[0]) begin
                  // pop the head; stop once the next entry is not due
                  op                   = OP_POP;
                  free_in[slot_arr[0]] = 1'b1;
                  rsp_status_in        = STAT_OK;
                  rsp_tag_in           = TAG_W'(tag_arr[0]);
                  rsp_last_in          = !due_vec[1];
                  if (!due_vec[1]) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_status_in = STAT_NONE;
                  rsp_tag_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_QUERY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_handle_in = '0;
               rsp_tag_in    = '0;
               rsp_last_in   = 1'b1;
               if (!valid_vec[0]) begin
                  rsp_sleep_in = '0;
               end else if (due_vec[0]) begin
                  rsp_sleep_in = '1;
               end else begin
                  rsp_sleep_in = dl_arr[0] - now_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: request capture, deadline sum, response beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff    <= req_bus.action;
         now_ff    <= req_bus.now;
         delay_ff  <= req_bus.delay_cycles;
         tag_ff    <= TAG_BITS'(req_bus.callback_tag);
         handle_ff <= req_bus.cancel_handle;
      end
      when_ff       <= when_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_sleep_ff  <= rsp_sleep_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.new_handle   = rsp_handle_ff;
   assign rsp_bus.fired_tag    = rsp_tag_ff;
   assign rsp_bus.sleep_cycles = rsp_sleep_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // every handle is either free or held by exactly one live cell
   a_handle_balance: assert property (@(posedge clock) disable iff (reset)
      ($countones(free_ff) + $countones(valid_vec)) == DEPTH)
      else $error("free handles and live entries do not add up to DEPTH");

   // the chain is dense whenever a new request can enter
   a_dense_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hole)
      else $error("hole in the chain while idle");

   // an accepted request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE) && (act_ff == $past(req_bus.action)))
      else $error("accepted request did not start");

   // a nothing-due beat is always the last of its request
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_NONE)) |-> rsp_last_ff)
      else $error("nothing-due beat without last");

endmodule

`default_nettype wire

// ----- design/sto_cell.sv -----
// One cell of the sorted timeout chain: holds one entry and trades it with its neighbors.
// Depends on sto_pkg.
`default_nettype none

module sto_cell import sto_pkg::*; #(
   parameter int TAG_BITS  = 16,
   parameter int SLOT_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic [SLOT_BITS-1:0] new_slot,
   input  logic [SLOT_BITS-1:0] drop_slot,
   input  logic                 left_valid,
   input  logic                 left_stay,
   input  logic [TIME_BITS-1:0] left_deadline,
   input  logic [TAG_BITS-1:0]  left_tag,
   input  logic [SLOT_BITS-1:0] left_slot,
   input  logic                 right_valid,
   input  logic [TIME_BITS-1:0] right_deadline,
   input  logic [TAG_BITS-1:0]  right_tag,
   input  logic [SLOT_BITS-1:0] right_slot,
   output logic                 valid,
   output logic                 stay,
   output logic                 due,
   output logic [TIME_BITS-1:0] deadline,
   output logic [TAG_BITS-1:0]  tag,
   output logic [SLOT_BITS-1:0] slot
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;

   assign stay = valid_ff && (deadline_ff < ctrl.when);
   assign due  = valid_ff && (deadline_ff <= ctrl.now);

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      tag_in      = tag_ff;
      slot_in     = slot_ff;
      case (ctrl.op)
         OP_INSERT: begin
            // earlier deadlines hold, the new entry lands at the boundary, the rest shift right
            if (!stay) begin
               if (left_stay) begin
                  valid_in    = 1'b1;
                  deadline_in = ctrl.when;
                  tag_in      = new_tag;
                  slot_in     = new_slot;
               end else begin
                  valid_in    = left_valid;
                  deadline_in = left_deadline;
                  tag_in      = left_tag;
                  slot_in     = left_slot;
               end
            end
         end
         OP_DROP: begin
            if (valid_ff && (slot_ff == drop_slot)) begin
               valid_in = 1'b0;
            end
         end
         OP_COMPACT: begin
            // a hole pulls the right neighbor in; an entry next to a hole leaves
            if (!valid_ff) begin
               valid_in    = right_valid;
               deadline_in = right_deadline;
               tag_in      = right_tag;
               slot_in     = right_slot;
            end else if (!left_valid) begin
               valid_in = 1'b0;
            end
         end
         OP_POP: begin
            valid_in    = right_valid;
            deadline_in = right_deadline;
            tag_in      = right_tag;
            slot_in     = right_slot;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      tag_ff      <= tag_in;
      slot_ff     <= slot_in;
   end

   assign valid    = valid_ff;
   assign deadline = deadline_ff;
   assign tag      = tag_ff;
   assign slot     = slot_ff;

endmodule

`default_nettype wire
